// ===== hdl/sse_pkg.sv =====
// Shared constants, codes and the decoded-edit struct for the subword store editor.
// No dependencies; every other file in hdl/ but sse_word_ram uses this package by scoped name.
`default_nettype none

package sse_pkg;

    // Store geometry
    localparam int ROWS          = 16;
    localparam int WORDS_PER_ROW = 64;

    // Fixed field widths of the transaction payloads
    localparam int OPC_W    = 2;
    localparam int SIZE_W   = 2;
    localparam int ROW_W    = 4;
    localparam int POS_W    = 10;
    localparam int DATA_W   = 32;
    localparam int WIDX_W   = 6;
    localparam int RLEN_W   = 7;

    // Derived widths
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH     = ROWS * WORDS_PER_ROW;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LEN_W     = $clog2(WORDS_PER_ROW + 1);

    // Opcodes
    localparam logic [OPC_W-1:0] OP_MODIFY = 2'd0;
    localparam logic [OPC_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPC_W-1:0] OP_SWAP   = 2'd2;

    // Element sizes
    localparam logic [SIZE_W-1:0] SZ_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] SZ_HALF = 2'd1;
    localparam logic [SIZE_W-1:0] SZ_WORD = 2'd2;

    // Result status
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_IGNORED = 1'b1;

    // One edit after decode, held while the word is read back
    typedef struct packed {
        logic                  ok;        // edit is legal and will be applied
        logic [OPC_W-1:0]      opcode;
        logic [SIZE_W-1:0]     size_code;
        logic [POS_W-1:0]      pos;       // word within the row
        logic [1:0]            byte_lane; // lowest byte of the element in the word
        logic                  in_len;    // word lies inside the current row length
        logic [LEN_W-1:0]      len;       // row length before the edit
        logic [ROW_IDX_W-1:0]  row_idx;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_W-1:0]     value;
    } sse_op_t;

endpackage

`default_nettype wire

// ===== hdl/sse_in_if.sv =====
// Edit channel: valid/ready handshake plus the edit payload.
// Depends on sse_pkg for field widths.
`default_nettype none

interface sse_in_if;
    logic                         valid;
    logic                         ready;
    logic [sse_pkg::OPC_W-1:0]    opcode;
    logic [sse_pkg::SIZE_W-1:0]   size_code;
    logic [sse_pkg::ROW_W-1:0]    row;
    logic [sse_pkg::POS_W-1:0]    element_index;
    logic [sse_pkg::DATA_W-1:0]   value;

    modport source (output valid, output opcode, output size_code, output row,
                    output element_index, output value, input ready);
    modport sink   (input valid, input opcode, input size_code, input row,
                    input element_index, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/sse_out_if.sv =====
// Result channel: valid/ready handshake plus the result payload.
// Depends on sse_pkg for field widths.
`default_nettype none

interface sse_out_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [sse_pkg::WIDX_W-1:0]   word_index;
    logic [sse_pkg::DATA_W-1:0]   word_after;
    logic [sse_pkg::RLEN_W-1:0]   row_length;

    modport source (output valid, output status, output word_index,
                    output word_after, output row_length, input ready);
    modport sink   (input valid, input status, input word_index,
                    input word_after, input row_length, output ready);
endinterface

`default_nettype wire

// ===== hdl/subword_store_editor.sv =====
// Subword store editor, top level: control, row lengths, result register.
// Depends on sse_pkg, sse_in_if, sse_out_if, sse_word_ram, sse_decode, sse_lane_alu.
`default_nettype none

// The block keeps ROWS rows of up to WORDS_PER_ROW 32-bit words in one synchronous
// RAM, plus a length per row in flops. Each edit transaction on edit_in names a
// row, an element size (byte, halfword, word) and an element index, and yields
// exactly one result transaction on result_out. Modify and delete count elements
// from one, swap counts from zero. Modify writes the value (masked to the element
// width) and grows the row when the element lies past its end; delete clears the
// element; swap reverses the bytes of a halfword or word and leaves a byte alone.
// Illegal edits (bad opcode or size, row or word out of range, index zero for
// modify/delete, delete/swap past the row length) change nothing and return
// status 1 with word_index and word_after zero and the row's current length.
// Transactions are handled one at a time: the word is read from the RAM into its
// registered read port, then modified, written back and loaded into the result
// register. edit_in.ready is high only between transactions; the execute cycle
// waits while an earlier result is still held on result_out. After reset a
// clearing pass writes zero to all DEPTH (1024) words, one word per cycle, so
// words that a row gains by growth read as zero; edit_in.ready stays low until
// the last word is cleared, and the first edit can be taken in the cycle after.

module subword_store_editor (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sse_in_if.sink      edit_in,
    sse_out_if.source   result_out
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                          state_reg;
    sse_pkg::sse_op_t                op_reg;
    sse_pkg::sse_op_t                op_next;

    logic [sse_pkg::LEN_W-1:0]       len_reg [sse_pkg::ROWS];
    logic [sse_pkg::LEN_W-1:0]       len_rd;

    logic [sse_pkg::ADDR_W-1:0]      clr_addr_reg;

    logic                            out_valid_reg;
    logic                            status_reg;
    logic [sse_pkg::WIDX_W-1:0]      word_index_reg;
    logic [sse_pkg::DATA_W-1:0]      word_after_reg;
    logic [sse_pkg::RLEN_W-1:0]      row_length_reg;

    logic                            accept;
    logic                            fire;      // execute cycle completes
    logic                            clearing;  // post-reset zero fill of the RAM
    logic                            grow;
    logic [sse_pkg::LEN_W-1:0]       len_after;
    logic [sse_pkg::DATA_W-1:0]      rd_word;
    logic [sse_pkg::DATA_W-1:0]      new_word;
    logic                            ram_wr_en;
    logic                            mem_wr_en;
    logic [sse_pkg::ADDR_W-1:0]      mem_wr_addr;
    logic [sse_pkg::DATA_W-1:0]      mem_wr_data;

    // Handshake: one edit in flight at a time
    assign clearing      = (state_reg == ST_CLEAR);
    assign edit_in.ready = (state_reg == ST_IDLE);
    assign accept        = edit_in.valid && edit_in.ready;
    assign fire          = (state_reg == ST_EXEC) && (!out_valid_reg || result_out.ready);

    // Row length lookup; out-of-range rows are masked inside the decoder
    assign len_rd = len_reg[sse_pkg::ROW_IDX_W'(edit_in.row)];

    sse_decode u_decode (
        .opcode        (edit_in.opcode),
        .size_code     (edit_in.size_code),
        .row           (edit_in.row),
        .element_index (edit_in.element_index),
        .value         (edit_in.value),
        .row_len       (len_rd),
        .op            (op_next)
    );

    // Write port: zero fill after reset, then edit write-back
    assign mem_wr_en   = clearing || ram_wr_en;
    assign mem_wr_addr = clearing ? clr_addr_reg : op_reg.addr;
    assign mem_wr_data = clearing ? '0 : new_word;

    sse_word_ram #(
        .DATA_W (sse_pkg::DATA_W),
        .DEPTH  (sse_pkg::DEPTH),
        .ADDR_W (sse_pkg::ADDR_W)
    ) u_word_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (op_next.addr),
        .rd_data (rd_word),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    sse_lane_alu u_lane_alu (
        .op       (op_reg),
        .rd_word  (rd_word),
        .new_word (new_word)
    );

    // Write back only legal edits; the read data stays put while we wait
    assign ram_wr_en = fire && op_reg.ok;
    assign grow      = op_reg.ok && (op_reg.opcode == sse_pkg::OP_MODIFY) && !op_reg.in_len;
    assign len_after = grow ? sse_pkg::LEN_W'(32'(op_reg.pos) + 32'd1) : op_reg.len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sse_pkg::ROWS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (fire && grow)
        begin
            len_reg[op_reg.row_idx] <= len_after;
        end
    end

    // Decoded edit, held across the read cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= sse_pkg::ST_DONE;
            word_index_reg <= '0;
            word_after_reg <= '0;
            row_length_reg <= '0;
        end
        else
        begin
            if (result_out.valid && result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + sse_pkg::ADDR_W'(1);
                    if (clr_addr_reg == sse_pkg::ADDR_W'(sse_pkg::DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (fire)
                    begin
                        state_reg      <= ST_IDLE;
                        out_valid_reg  <= 1'b1;
                        row_length_reg <= sse_pkg::RLEN_W'(len_after);
                        if (op_reg.ok)
                        begin
                            status_reg     <= sse_pkg::ST_DONE;
                            word_index_reg <= sse_pkg::WIDX_W'(op_reg.pos);
                            word_after_reg <= new_word;
                        end
                        else
                        begin
                            status_reg     <= sse_pkg::ST_IGNORED;
                            word_index_reg <= '0;
                            word_after_reg <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.status     = status_reg;
    assign result_out.word_index = word_index_reg;
    assign result_out.word_after = word_after_reg;
    assign result_out.row_length = row_length_reg;

    // An accepted edit always moves to the execute cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_EXEC))
        else $error("accepted edit did not enter execute");

    // RAM writes happen only for legal edits in the execute cycle
    a_write_legal: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> ((state_reg == ST_EXEC) && op_reg.ok))
        else $error("RAM write outside a legal execute cycle");

    // A row only grows, and never past its capacity
    a_grow_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && grow) |-> ((32'(len_after) > 32'(op_reg.len))
                         && (32'(len_after) <= 32'(sse_pkg::WORDS_PER_ROW))))
        else $error("row length update out of bounds");

    // A done result always names a word inside the row
    a_done_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && (result_out.status == sse_pkg::ST_DONE))
        |-> (32'(result_out.word_index) < 32'(result_out.row_length)))
        else $error("done result points past the row length");

    // No new edit is taken while one is executing
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !accept)
        else $error("edit accepted while another is in flight");

    // No edit is taken during the zero fill
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !edit_in.ready)
        else $error("edit_in ready during the clearing pass");

endmodule

`default_nettype wire

// ===== hdl/sse_word_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module sse_word_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sse_decode.sv =====
// Edit decode: element placement, range checks and memory address.
// Depends on sse_pkg.
`default_nettype none

module sse_decode (
    input  wire logic [sse_pkg::OPC_W-1:0]   opcode,
    input  wire logic [sse_pkg::SIZE_W-1:0]  size_code,
    input  wire logic [sse_pkg::ROW_W-1:0]   row,
    input  wire logic [sse_pkg::POS_W-1:0]   element_index,
    input  wire logic [sse_pkg::DATA_W-1:0]  value,
    input  wire logic [sse_pkg::LEN_W-1:0]   row_len,  // stored length of the row
    output sse_pkg::sse_op_t                 op
);

    logic                         row_ok;
    logic [sse_pkg::POS_W-1:0]    elem;
    logic [sse_pkg::POS_W-1:0]    pos;
    logic [1:0]                   lane;
    logic [sse_pkg::LEN_W-1:0]    len;
    logic [sse_pkg::ROW_IDX_W-1:0] row_idx;
    logic                         legal;
    logic                         in_len;

    always_comb
    begin
        row_ok  = 32'(row) < 32'(sse_pkg::ROWS);
        row_idx = sse_pkg::ROW_IDX_W'(row);
        len     = row_ok ? row_len : '0;

        // swap counts from zero, modify and delete from one
        elem = (opcode == sse_pkg::OP_SWAP) ? element_index
                                            : element_index - sse_pkg::POS_W'(1);

        case (size_code)
            sse_pkg::SZ_BYTE:
            begin
                pos  = {2'b00, elem[sse_pkg::POS_W-1:2]};
                lane = elem[1:0];
            end
            sse_pkg::SZ_HALF:
            begin
                pos  = {1'b0, elem[sse_pkg::POS_W-1:1]};
                lane = {elem[0], 1'b0};
            end
            default:
            begin
                pos  = elem;
                lane = 2'b00;
            end
        endcase

        in_len = 32'(pos) < 32'(len);

        legal = (opcode inside {sse_pkg::OP_MODIFY, sse_pkg::OP_DELETE, sse_pkg::OP_SWAP})
             && (size_code inside {sse_pkg::SZ_BYTE, sse_pkg::SZ_HALF, sse_pkg::SZ_WORD})
             && row_ok;
        if (opcode != sse_pkg::OP_SWAP && element_index == '0)
        begin
            legal = 1'b0;
        end
        if (32'(pos) >= 32'(sse_pkg::WORDS_PER_ROW))
        begin
            legal = 1'b0;
        end
        if (opcode != sse_pkg::OP_MODIFY && !in_len)
        begin
            legal = 1'b0;
        end

        op.ok        = legal;
        op.opcode    = opcode;
        op.size_code = size_code;
        op.pos       = pos;
        op.byte_lane = lane;
        op.in_len    = in_len;
        op.len       = len;
        op.row_idx   = row_idx;
        op.addr      = sse_pkg::ADDR_W'(32'(row_idx) * 32'(sse_pkg::WORDS_PER_ROW)
                                        + 32'(pos));
        op.value     = value;
    end

endmodule

`default_nettype wire

// ===== hdl/sse_lane_alu.sv =====
// Word modify unit: byte/halfword/word insert, clear and byte reversal.
// Depends on sse_pkg.
`default_nettype none

module sse_lane_alu (
    input  wire sse_pkg::sse_op_t            op,
    input  wire logic [sse_pkg::DATA_W-1:0]  rd_word,
    output logic      [sse_pkg::DATA_W-1:0]  new_word
);

    logic [4:0]                  shamt;
    logic [sse_pkg::DATA_W-1:0]  old_word;
    logic [sse_pkg::DATA_W-1:0]  mask;
    logic [15:0]                 half;

    always_comb
    begin
        shamt = {op.byte_lane, 3'b000};
        // words past the row length were never written by an edit: they read as zero
        old_word = op.in_len ? rd_word : '0;
        half     = 16'(old_word >> shamt);

        case (op.size_code)
            sse_pkg::SZ_BYTE: mask = 32'h000000ff << shamt;
            sse_pkg::SZ_HALF: mask = 32'h0000ffff << shamt;
            default:          mask = 32'hffffffff;
        endcase

        case (op.opcode)
            sse_pkg::OP_MODIFY:
            begin
                new_word = (old_word & ~mask) | ((op.value << shamt) & mask);
            end
            sse_pkg::OP_DELETE:
            begin
                new_word = old_word & ~mask;
            end
            sse_pkg::OP_SWAP:
            begin
                case (op.size_code)
                    sse_pkg::SZ_WORD:
                    begin
                        new_word = {old_word[7:0], old_word[15:8],
                                    old_word[23:16], old_word[31:24]};
                    end
                    sse_pkg::SZ_HALF:
                    begin
                        new_word = (old_word & ~mask)
                                 | (32'({half[7:0], half[15:8]}) << shamt);
                    end
                    default:
                    begin
                        new_word = old_word;
                    end
                endcase
            end
            default:
            begin
                new_word = old_word;
            end
        endcase
    end

endmodule

`default_nettype wire
